// ===== sv/cbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpg_pkg
// Fixed-point widths and constants shared by the Bezier point generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  localparam int FRAC_W     = 16;     // Q1.15 fraction on the input channel
  localparam int T_W        = 16;     // curve parameter t, unsigned Q1.15
  localparam int U_W        = 17;     // 1 - t, signed Q2.15
  localparam int U2_W       = 18;     // (1-t)^2, held signed, never negative
  localparam int T2_W       = 17;     // t^2, unsigned
  localparam int MW         = 36;     // Bernstein partial products
  localparam int BW         = 21;     // Bernstein weights, signed
  localparam int SHIFT      = 15;     // Q.15 product scaling
  localparam int FRAC_ONE   = 32768;  // 1.0 in Q1.15
  localparam int ROUND_BIAS = 16384;  // half an lsb before the final shift

endpackage

// ===== sv/cbpg_if.sv =====
// ----------------------------------------------------------------------------
// cbpg_in_if / cbpg_out_if
// Valid/ready channels for Bezier segments in and curve points out.
// ----------------------------------------------------------------------------
interface cbpg_in_if
  import cbpg_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] ctrl_a_x;
  logic signed [COORD_WIDTH-1:0] ctrl_a_y;
  logic signed [COORD_WIDTH-1:0] ctrl_b_x;
  logic signed [COORD_WIDTH-1:0] ctrl_b_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic        [FRAC_W-1:0]      fraction;

  modport source (
    output valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y, fraction,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y, fraction,
    output ready
  );
endinterface

interface cbpg_out_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input  valid, point_x, point_y, last_point, output ready);
endinterface

// ===== sv/cubic_bezier_point_generator.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// Throughput: one point per cycle while the output is not stalled; SEGMENTS+1
//   points per segment (33 at the default), set by the point sequencer.
// Reset: synchronous, active high; clears sequencer and stage valid bits.
// ----------------------------------------------------------------------------
//
// Structure
//   Sequencer: latches one segment and issues one point token per cycle unless stalled.
//     It keeps n = i*fraction by accumulation, so no multiply is needed there.
//     The closing token reuses the n of point SEGMENTS-1, which gives the
//     repeated point for free when the fraction is below one.
//     A new segment transfer is taken in the same cycle as the closing token
//     leaves, so segments follow back to back.
//   Ten register stages, each with its own valid bit; a stage moves when it
//   is empty or the stage after it moves, so bubbles collapse and a stall at
//   the output holds everything in place without dropping a point.
//     1  n * reciprocal of SEGMENTS
//     2  quotient estimate and remainder
//     3  quotient correction: t = floor(n / SEGMENTS)
//     4  u = 1 - t, u*u, t*t
//     5  (1-t)^2, t^2 and the four Bernstein products
//     6  x3 and Q.15 scaling: weights b0..b3
//     7  weight times coordinate, both axes
//     8  pairwise sums
//     9  full sum
//     10 round half up, saturate, end-point override; output register
//
module cubic_bezier_point_generator
  import cbpg_pkg::*;
#(
  parameter int SEGMENTS    = 32,
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  cbpg_in_if.sink    curve,
  cbpg_out_if.source points
);

  localparam int CW  = COORD_WIDTH;
  localparam int IW  = $clog2(SEGMENTS + 1);        // point index
  localparam int NW  = FRAC_W + $clog2(SEGMENTS);   // i * fraction
  localparam int RW  = $clog2(2 * SEGMENTS);        // remainder before fix-up
  localparam int PW  = BW + CW;                     // weight * coordinate
  localparam int AW  = PW + 1;                      // pair sums
  localparam int SW  = PW + 2;                      // full sum
  localparam int VW  = SW - SHIFT;                  // after scaling
  localparam int NST = 10;

  // floor(2^NW / SEGMENTS); quotient estimate is low by at most one
  localparam logic [NW-1:0] RECIP = NW'((1 << NW) / SEGMENTS);

  localparam logic signed [VW-1:0] SAT_HI = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic                 last;
    logic                 fhi;   // fraction at least one
    logic signed [CW-1:0] sx, sy, ax, ay, bx, by, ex, ey;
  } ctx_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Point sequencer
  // --------------------------------------------------------------------------
  logic              busy;
  logic [IW-1:0]     idx;
  logic [NW-1:0]     n;
  logic [FRAC_W-1:0] frac;
  ctx_t              held;

  logic              last_tok;
  logic              accept;
  logic              issue;
  ctx_t              tok_ctx;
  logic [NST+1:1]    en;     // stage k loads this cycle
  logic [NST:1]      vld;

  assign last_tok = (idx == IW'(SEGMENTS));
  assign issue    = busy && en[1];
  // take the next segment while idle, or as the closing token leaves
  assign curve.ready = !busy || (last_tok && en[1]);
  assign accept      = curve.valid && curve.ready;

  always_comb begin
    tok_ctx      = held;
    tok_ctx.last = last_tok;
    tok_ctx.fhi  = (frac >= FRAC_W'(FRAC_ONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept) begin
      busy     <= 1'b1;
      idx      <= '0;
      n        <= '0;
      frac     <= curve.fraction;
      held     <= '{last: 1'b0, fhi: 1'b0,
                    sx: curve.start_x,  sy: curve.start_y,
                    ax: curve.ctrl_a_x, ay: curve.ctrl_a_y,
                    bx: curve.ctrl_b_x, by: curve.ctrl_b_y,
                    ex: curve.end_x,    ey: curve.end_y};
    end else if (issue) begin
      if (last_tok) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + IW'(1);
        // the closing token keeps the n of point SEGMENTS-1
        if (idx < IW'(SEGMENTS - 1)) begin
          n <= n + NW'(frac);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  always_comb begin
    en[NST+1] = points.ready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= busy;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  ctx_t ctx_q [1:NST];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctx_q[1] <= tok_ctx;
    end
    for (int k = 2; k <= NST; k++) begin
      if (en[k]) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-3: t = floor(n / SEGMENTS) by reciprocal and one fix-up
  // --------------------------------------------------------------------------
  logic [2*NW-1:0] prod1;
  logic [NW-1:0]   n1;
  logic [T_W-1:0]  q_c;
  logic [NW-1:0]   r_full;
  logic [T_W-1:0]  q2;
  logic [RW-1:0]   r2;
  logic [T_W-1:0]  t3;

  always_comb begin
    q_c    = prod1[NW +: T_W];
    r_full = n1 - (NW'(q_c) * NW'(SEGMENTS));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1 <= n * RECIP;
      n1    <= n;
    end
    if (en[2]) begin
      q2 <= q_c;
      r2 <= r_full[RW-1:0];
    end
    if (en[3]) begin
      t3 <= q2 + T_W'(r2 >= RW'(SEGMENTS));
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4-6: Bernstein weights, every Q.15 product floored
  // --------------------------------------------------------------------------
  logic signed [U_W-1:0]   u_c;
  logic signed [U_W-1:0]   u4;
  logic        [T_W-1:0]   t4;
  logic signed [2*U_W-1:0] uu4;
  logic        [2*T_W-1:0] tt4;
  logic signed [U2_W-1:0]  u2_c;
  logic        [T2_W-1:0]  t2_c;
  logic signed [MW-1:0]    m0, m1, m2, m3;
  logic signed [MW-1:0]    m1x3, m2x3;
  logic signed [BW-1:0]    b0, b1, b2, b3;

  always_comb begin
    u_c  = $signed(U_W'(FRAC_ONE) - {1'b0, t3});
    u2_c = $signed(uu4[SHIFT +: U2_W]);
    t2_c = tt4[SHIFT +: T2_W];
    m1x3 = m1 + (m1 <<< 1);
    m2x3 = m2 + (m2 <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      u4  <= u_c;
      t4  <= t3;
      uu4 <= u_c * u_c;
      tt4 <= t3 * t3;
    end
    if (en[5]) begin
      m0 <= MW'(u2_c) * MW'(u4);
      m1 <= MW'(u2_c) * MW'($signed({1'b0, t4}));
      m2 <= MW'(u4) * MW'($signed({1'b0, t2_c}));
      m3 <= MW'($signed({1'b0, t2_c})) * MW'($signed({1'b0, t4}));
    end
    if (en[6]) begin
      b0 <= $signed(m0[SHIFT +: BW]);
      b1 <= $signed(m1x3[SHIFT +: BW]);
      b2 <= $signed(m2x3[SHIFT +: BW]);
      b3 <= $signed(m3[SHIFT +: BW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7-10: weighted sum per axis, rounding and saturation
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prx [4];
  logic signed [PW-1:0] pry [4];
  logic signed [AW-1:0] sax, sbx, say, sby;
  logic signed [SW-1:0] sumx, sumy;
  logic signed [SW-1:0] rsx, rsy;
  logic signed [CW-1:0] point_x_q, point_y_q;
  logic                 last_q;

  always_comb begin
    rsx = sumx + SW'(ROUND_BIAS);
    rsy = sumy + SW'(ROUND_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      prx[0] <= PW'(b0) * PW'(ctx_q[6].sx);
      prx[1] <= PW'(b1) * PW'(ctx_q[6].ax);
      prx[2] <= PW'(b2) * PW'(ctx_q[6].bx);
      prx[3] <= PW'(b3) * PW'(ctx_q[6].ex);
      pry[0] <= PW'(b0) * PW'(ctx_q[6].sy);
      pry[1] <= PW'(b1) * PW'(ctx_q[6].ay);
      pry[2] <= PW'(b2) * PW'(ctx_q[6].by);
      pry[3] <= PW'(b3) * PW'(ctx_q[6].ey);
    end
    if (en[8]) begin
      sax <= AW'(prx[0]) + AW'(prx[1]);
      sbx <= AW'(prx[2]) + AW'(prx[3]);
      say <= AW'(pry[0]) + AW'(pry[1]);
      sby <= AW'(pry[2]) + AW'(pry[3]);
    end
    if (en[9]) begin
      sumx <= SW'(sax) + SW'(sbx);
      sumy <= SW'(say) + SW'(sby);
    end
    if (en[10]) begin
      last_q <= ctx_q[9].last;
      // closing point of a full curve is the end point, passed through
      if (ctx_q[9].last && ctx_q[9].fhi) begin
        point_x_q <= ctx_q[9].ex;
        point_y_q <= ctx_q[9].ey;
      end else begin
        point_x_q <= sat($signed(rsx[SW-1:SHIFT]));
        point_y_q <= sat($signed(rsy[SW-1:SHIFT]));
      end
    end
  end

  assign points.valid      = vld[NST];
  assign points.point_x    = point_x_q;
  assign points.point_y    = point_y_q;
  assign points.last_point = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // accumulator tracks i * fraction for every ordinary point
  a_n_track: assert property (@(posedge clk) disable iff (rst)
    (busy && !last_tok) |-> (n == NW'(idx) * NW'(frac)))
    else $error("point accumulator out of step with index");

  // a segment transfer always starts a run at point zero
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && idx == '0))
    else $error("run did not start at point zero");

  // closing token with no new segment leaves the sequencer idle
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (issue && last_tok && !accept) |=> !busy)
    else $error("sequencer still busy after closing point");

endmodule
